FILE: src/spcm_pkg.sv
// Shared types, register indexes and decode helpers for the PCM16 sample converter.
package spcm_pkg;

   localparam int unsigned RAW_W    = 32;
   localparam int unsigned EXP_W    = 8;
   localparam int unsigned PCM_W    = 16;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 6;
   localparam int unsigned DEPTH_W    = 6;
   localparam int unsigned LAYOUT_W   = 2;

   // Single-precision field widths and the scaled product width (24 x 15 bits).
   localparam int unsigned MAN_W  = 23;
   localparam int unsigned SIG_W  = MAN_W + 1;
   localparam int unsigned PROD_W = SIG_W + 15;
   localparam int unsigned RND_W  = SIG_W + 1;

   localparam logic [EXP_W-1:0]   EXP_ONE   = 8'd127;
   localparam logic [EXP_W-1:0]   EXP_SPEC  = 8'd255;
   localparam logic [EXP_W-1:0]   SHIFT_HI  = 8'd135;  // 150 - 15
   localparam logic [EXP_W-1:0]   SHIFT_LO  = 8'd136;  // 150 - 14
   localparam logic [EXP_W-1:0]   SHIFT_OUT = 8'd25;   // at or beyond this nothing is left
   localparam logic [PCM_W-1:0]   PCM_FULL  = 16'h7FFF;
   localparam logic [DEPTH_W-1:0] DEPTH_RESET = 6'd16;
   localparam logic [DEPTH_W-1:0] DEPTH_24    = 6'd24;
   localparam logic [DEPTH_W-1:0] DEPTH_32    = 6'd32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE_IS_FLOAT  = 2'd0,
      CSR_FLOAT_LAYOUT     = 2'd1,
      CSR_SOURCE_BIT_DEPTH = 2'd2
   } csr_index_type;

   typedef enum logic [LAYOUT_W-1:0] {
      LAYOUT_REBUILD = 2'd0,
      LAYOUT_LOW16   = 2'd1,
      LAYOUT_SHIFT8  = 2'd2
   } layout_type;

   typedef struct packed {
      logic                  source_is_float;
      logic [LAYOUT_W-1:0]   float_layout;
      logic [DEPTH_W-1:0]    source_bit_depth;
   } cfg_type;

   typedef enum logic [1:0] {
      MODE_FLOAT  = 2'd0,
      MODE_LOW16  = 2'd1,
      MODE_MID16  = 2'd2,
      MODE_HIGH16 = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CLASS_ZERO   = 2'd0,
      CLASS_FULL   = 2'd1,
      CLASS_NORMAL = 2'd2
   } class_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_load_type;

   function automatic mode_type decode_mode(input cfg_type cfg);
      mode_type m;
      m = MODE_LOW16;
      if (cfg.source_is_float) begin
         case (cfg.float_layout)
            LAYOUT_REBUILD: m = MODE_FLOAT;
            LAYOUT_LOW16:   m = MODE_LOW16;
            default:        m = MODE_MID16;
         endcase
      end else if (cfg.source_bit_depth == DEPTH_24) begin
         m = MODE_MID16;
      end else if (cfg.source_bit_depth == DEPTH_32) begin
         m = MODE_HIGH16;
      end
      return m;
   endfunction

   function automatic logic [PCM_W-1:0] int_select(input mode_type m,
                                                    input logic [RAW_W-1:0] raw);
      logic [PCM_W-1:0] r;
      case (m)
         MODE_MID16:  r = raw[23:8];
         MODE_HIGH16: r = raw[31:16];
         default:     r = raw[15:0];
      endcase
      return r;
   endfunction

endpackage

FILE: src/spcm_csr.sv
// Configuration registers of the PCM16 sample converter.
module spcm_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [spcm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [spcm_pkg::CSR_DATA_W-1:0]      csr_write_data,
   output spcm_pkg::cfg_type                    cfg
);
   import spcm_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_SOURCE_IS_FLOAT:  cfg_in.source_is_float  = csr_write_data[0];
            CSR_FLOAT_LAYOUT:     cfg_in.float_layout     = csr_write_data[LAYOUT_W-1:0];
            CSR_SOURCE_BIT_DEPTH: cfg_in.source_bit_depth = csr_write_data[DEPTH_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_is_float  <= 1'b0;
         cfg_ff.float_layout     <= LAYOUT_REBUILD;
         cfg_ff.source_bit_depth <= DEPTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/spcm_flow_ctrl.sv
// Valid bits and per-stage load enables of the four-stage conversion pipeline.
module spcm_flow_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output spcm_pkg::stage_load_type ld
);
   import spcm_pkg::*;

   logic [3:0] valid_ff, valid_in;
   logic [3:0] open_stage;

   // A stage can take a new item when empty or when its own item moves on.
   always_comb begin
      open_stage[3] = !valid_ff[3] || rsp_ready;
      open_stage[2] = !valid_ff[2] || open_stage[3];
      open_stage[1] = !valid_ff[1] || open_stage[2];
      open_stage[0] = !valid_ff[0] || open_stage[1];

      ld.s1 = open_stage[0] && req_valid;
      ld.s2 = open_stage[1] && valid_ff[0];
      ld.s3 = open_stage[2] && valid_ff[1];
      ld.s4 = open_stage[3] && valid_ff[2];

      valid_in[0] = open_stage[0] ? req_valid   : valid_ff[0];
      valid_in[1] = open_stage[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = open_stage[2] ? valid_ff[1] : valid_ff[2];
      valid_in[3] = open_stage[3] ? valid_ff[2] : valid_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = open_stage[0];
   assign rsp_valid = valid_ff[3];

endmodule

FILE: src/spcm_datapath.sv
// Payload stages: input capture, scaled product, rounding, final shift and output register.
module spcm_datapath (
   input  logic                                  clock,
   input  spcm_pkg::stage_load_type              ld,
   input  spcm_pkg::cfg_type                     cfg,
   input  logic signed [spcm_pkg::RAW_W-1:0]     req_raw_sample,
   input  logic [spcm_pkg::EXP_W-1:0]            req_exponent_byte,
   output logic signed [spcm_pkg::PCM_W-1:0]     rsp_pcm_sample
);
   import spcm_pkg::*;

   // Stage 1: captured item and decoded mode.
   logic [RAW_W-1:0]  s1_raw_ff;
   logic [EXP_W-1:0]  s1_exp_ff;
   mode_type          s1_mode_ff;

   // Stage 2: significand times 32767, class and integer result.
   logic [PROD_W-1:0] s2_prod_ff, s2_prod_in;
   logic [EXP_W-1:0]  s2_exp_ff;
   logic              s2_neg_ff;
   class_type         s2_class_ff, s2_class_in;
   logic              s2_float_ff;
   logic [PCM_W-1:0]  s2_int_ff;

   // Stage 3: product rounded to 24 significant bits, and the right shift still due.
   logic [RND_W-1:0]  s3_rnd_ff, s3_rnd_in;
   logic [EXP_W-1:0]  s3_shift_ff, s3_shift_in;
   logic              s3_neg_ff;
   class_type         s3_class_ff;
   logic              s3_float_ff;
   logic [PCM_W-1:0]  s3_int_ff;

   logic [PCM_W-1:0]  pcm_ff, pcm_in;

   logic [MAN_W-1:0]  man;
   logic [SIG_W-1:0]  sig;
   logic [SIG_W-1:0]  kept;
   logic              round_up;
   logic [RND_W-1:0]  shifted;
   logic [PCM_W-1:0]  mag;

   // The magnitude's low 23 bits equal the 23-bit negation of the raw low bits.
   always_comb begin
      man = s1_raw_ff[RAW_W-1] ? (~s1_raw_ff[MAN_W-1:0] + MAN_W'(1))
                               : s1_raw_ff[MAN_W-1:0];
      sig = {1'b1, man};
      s2_prod_in = {sig, 15'd0} - {15'd0, sig};
      if (s1_exp_ff == EXP_SPEC && man != '0) begin
         s2_class_in = CLASS_ZERO;
      end else if (s1_exp_ff >= EXP_ONE) begin
         s2_class_in = CLASS_FULL;
      end else if (s1_exp_ff == '0) begin
         // Denormals are far below one output step.
         s2_class_in = CLASS_ZERO;
      end else begin
         s2_class_in = CLASS_NORMAL;
      end
   end

   // A normal product has 38 or 39 bits, so only its top bit picks the rounding point.
   always_comb begin
      if (s2_prod_ff[PROD_W-1]) begin
         kept        = s2_prod_ff[PROD_W-1:15];
         round_up    = s2_prod_ff[14] && ((|s2_prod_ff[13:0]) || kept[0]);
         s3_shift_in = SHIFT_HI - s2_exp_ff;
      end else begin
         kept        = s2_prod_ff[PROD_W-2:14];
         round_up    = s2_prod_ff[13] && ((|s2_prod_ff[12:0]) || kept[0]);
         s3_shift_in = SHIFT_LO - s2_exp_ff;
      end
      s3_rnd_in = {1'b0, kept} + {{SIG_W{1'b0}}, round_up};
   end

   always_comb begin
      shifted = s3_rnd_ff >> s3_shift_ff[4:0];
      if (s3_shift_ff >= SHIFT_OUT) begin
         mag = '0;
      end else begin
         mag = shifted[PCM_W-1:0];
      end
      case (s3_class_ff)
         CLASS_FULL:   pcm_in = PCM_FULL;
         CLASS_NORMAL: pcm_in = mag;
         default:      pcm_in = '0;
      endcase
      if (s3_neg_ff) begin
         pcm_in = ~pcm_in + PCM_W'(1);
      end
      if (!s3_float_ff) begin
         pcm_in = s3_int_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld.s1) begin
         s1_raw_ff  <= req_raw_sample;
         s1_exp_ff  <= req_exponent_byte;
         s1_mode_ff <= decode_mode(cfg);
      end
      if (ld.s2) begin
         s2_prod_ff  <= s2_prod_in;
         s2_exp_ff   <= s1_exp_ff;
         s2_neg_ff   <= s1_raw_ff[RAW_W-1];
         s2_class_ff <= s2_class_in;
         s2_float_ff <= (s1_mode_ff == MODE_FLOAT);
         s2_int_ff   <= int_select(s1_mode_ff, s1_raw_ff);
      end
      if (ld.s3) begin
         s3_rnd_ff   <= s3_rnd_in;
         s3_shift_ff <= s3_shift_in;
         s3_neg_ff   <= s2_neg_ff;
         s3_class_ff <= s2_class_ff;
         s3_float_ff <= s2_float_ff;
         s3_int_ff   <= s2_int_ff;
      end
      if (ld.s4) begin
         pcm_ff <= pcm_in;
      end
   end

   assign rsp_pcm_sample = pcm_ff;

endmodule

FILE: src/audio_sample_to_pcm16_converter_core.sv
// Top level of the PCM16 sample converter.
//
// Input channel req_*: one decoded sample (req_raw_sample) and a biased
// exponent (req_exponent_byte) per item. Result channel rsp_*: one signed
// 16-bit sample (rsp_pcm_sample) per item, in order. Both use valid/ready.
// The csr_* port writes the three mode registers; write them only while no
// item is in flight.
// An item passes four registers (capture, scaled product, rounding, output
// with final shift) before its result is offered on rsp_*.
// One item is taken every cycle while the receiver keeps rsp_ready high; the
// rate is set by the single output register draining once per cycle.
// When the receiver stalls, each stage keeps its item and the empty stages
// in front of it still fill, so up to four items are held before req_ready
// drops. Reset empties the pipeline and sets integer mode, 16-bit depth.
module audio_sample_to_pcm16_converter_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [spcm_pkg::RAW_W-1:0]    req_raw_sample,
   input  logic [spcm_pkg::EXP_W-1:0]           req_exponent_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [spcm_pkg::PCM_W-1:0]    rsp_pcm_sample,
   input  logic                                 csr_write_enable,
   input  logic [spcm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [spcm_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import spcm_pkg::*;

   cfg_type        cfg;
   stage_load_type ld;

   spcm_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   spcm_flow_ctrl u_flow (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ld        (ld)
   );

   spcm_datapath u_datapath (
      .clock             (clock),
      .ld                (ld),
      .cfg               (cfg),
      .req_raw_sample    (req_raw_sample),
      .req_exponent_byte (req_exponent_byte),
      .rsp_pcm_sample    (rsp_pcm_sample)
   );

endmodule

FILE: src/spcm_checker.sv
// Port-level checks of the PCM16 sample converter, bound to its top level.
module spcm_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [spcm_pkg::PCM_W-1:0]    rsp_pcm_sample
);

   // A held result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pcm_sample))
      else $error("result changed while stalled");

   // Reset leaves nothing in flight.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // With the output register empty the whole pipeline can move.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked while the output is empty");

   // An item taken while the output register is empty and the receiver stays ready is then offered.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
      |=> rsp_valid)
      else $error("result missing three cycles after acceptance");

endmodule

bind audio_sample_to_pcm16_converter_core spcm_checker u_spcm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_pcm_sample (rsp_pcm_sample)
);

FILE: sim/testbench.sv
// Self-checking testbench for the PCM16 sample converter core.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import spcm_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 11;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int LONG_HOLD    = 80;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 160;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // Holds the mode registers as the block should see them and the samples still owed.
   class pcm_scoreboard;
      logic                 is_float;
      logic [LAYOUT_W-1:0]  layout;
      logic [DEPTH_W-1:0]   depth;
      logic signed [PCM_W-1:0] owed_samples[$];
      int                   error_count;

      function new();
         is_float    = 1'b0;
         layout      = LAYOUT_REBUILD;
         depth       = DEPTH_RESET;
         error_count = 0;
      endfunction

      function void note_csr(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_SOURCE_IS_FLOAT:  is_float = data[0];
            CSR_FLOAT_LAYOUT:     layout = data[LAYOUT_W-1:0];
            CSR_SOURCE_BIT_DEPTH: depth = data;
            default: ;
         endcase
      endfunction

      // Rebuilds the single-precision value, clamps it, scales by 32767 with
      // round-to-nearest-even at 24 significant bits and truncates toward zero.
      function logic [PCM_W-1:0] float_to_pcm(logic [RAW_W-1:0] raw, logic [EXP_W-1:0] ex);
         logic              neg;
         logic [RAW_W-1:0]  mag;
         logic [MAN_W-1:0]  man;
         logic [63:0]       prod;
         logic [63:0]       bits_left;
         logic [63:0]       rem;
         logic [63:0]       half;
         logic [PCM_W-1:0]  res;
         int                len;
         int                d;
         int                t;
         int                scale;
         neg = raw[RAW_W-1];
         mag = neg ? (32'd0 - raw) : raw;
         man = mag[MAN_W-1:0];
         if (ex == EXP_SPEC && man != '0)
            return '0;
         if (ex >= EXP_ONE) begin
            res = PCM_FULL;
         end else begin
            prod = (ex == '0) ? {41'd0, man} : {40'd0, 1'b1, man};
            prod = prod * 64'd32767;
            scale = (ex == '0) ? -149 : int'(ex) - 150;
            len = 0;
            bits_left = prod;
            while (bits_left != '0) begin
               len++;
               bits_left = bits_left >> 1;
            end
            d = 0;
            if (len > SIG_W) begin
               d = len - SIG_W;
               rem = prod & ((64'd1 << d) - 64'd1);
               half = 64'd1 << (d - 1);
               prod = prod >> d;
               if (rem > half || (rem == half && prod[0]))
                  prod = prod + 64'd1;
            end
            t = d + scale;
            if (t >= 0) begin
               res = {1'b0, prod[14:0]};
            end else if (-t >= 64) begin
               res = '0;
            end else begin
               prod = prod >> (-t);
               res = prod[PCM_W-1:0];
            end
         end
         if (neg)
            res = 16'd0 - res;
         return res;
      endfunction

      function void note_sample(logic [RAW_W-1:0] raw, logic [EXP_W-1:0] ex);
         logic [PCM_W-1:0] pcm;
         if (is_float) begin
            if (layout == LAYOUT_REBUILD)
               pcm = float_to_pcm(raw, ex);
            else if (layout == LAYOUT_LOW16)
               pcm = raw[15:0];
            else
               pcm = raw[23:8];
         end else if (depth == DEPTH_24) begin
            pcm = raw[23:8];
         end else if (depth == DEPTH_32) begin
            pcm = raw[31:16];
         end else begin
            pcm = raw[15:0];
         end
         owed_samples = {owed_samples, pcm};
      endfunction

      function void check_sample(logic signed [PCM_W-1:0] actual);
         logic signed [PCM_W-1:0] wanted;
         if (owed_samples.size() == 0) begin
            $display("%0t: pcm_sample expected none, got %0d", $time, actual);
            error_count++;
            return;
         end
         wanted = owed_samples.pop_front();
         if (actual !== wanted) begin
            $display("%0t: pcm_sample expected %0d, got %0d", $time, wanted, actual);
            error_count++;
         end
      endfunction

      function int owed();
         return owed_samples.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [RAW_W-1:0] req_raw_sample = '0;
   logic [EXP_W-1:0] req_exponent_byte = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [PCM_W-1:0] rsp_pcm_sample;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   pcm_scoreboard sb = new();
   int  cycle_count = 0;
   bit  sender_idles = 1'b0;
   bit  receiver_idles = 1'b0;
   bit  hold_request = 1'b0;

   audio_sample_to_pcm16_converter_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_raw_sample    (req_raw_sample),
      .req_exponent_byte (req_exponent_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pcm_sample    (rsp_pcm_sample),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 98)
         return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   task automatic send_sample(input logic [RAW_W-1:0] raw, input logic [EXP_W-1:0] ex);
      int gap;
      gap = sender_idles ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_raw_sample <= raw;
      req_exponent_byte <= ex;
      do
         @(posedge clock);
      while (!req_ready);
      sb.note_sample(raw, ex);
   endtask

   // Stops offering items and waits until every owed sample has come out.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.owed() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      sb.note_csr(index, data);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_modes(input logic is_float, input logic [LAYOUT_W-1:0] layout,
                            input logic [DEPTH_W-1:0] depth);
      wait_drained();
      write_csr(CSR_SOURCE_IS_FLOAT, {5'd0, is_float});
      write_csr(CSR_FLOAT_LAYOUT, {4'd0, layout});
      write_csr(CSR_SOURCE_BIT_DEPTH, depth);
   endtask

   function automatic logic [RAW_W-1:0] random_float_raw();
      logic [RAW_W-1:0] m;
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1, 2: begin
            m = $urandom_range(0, 32'h007F_FFFF);
            return $urandom_range(0, 1) ? (32'd0 - m) : m;
         end
         3: return $urandom & 32'hFF80_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [EXP_W-1:0] random_float_exponent();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return EXP_W'($urandom_range(100, 126));
      else if (r < 60)
         return EXP_W'($urandom_range(127, 130));
      else if (r < 68)
         return '0;
      else if (r < 76)
         return EXP_SPEC;
      else if (r < 80)
         return 8'd254;
      return EXP_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [DEPTH_W-1:0] random_depth();
      case ($urandom_range(0, 5))
         0: return DEPTH_24;
         1: return DEPTH_32;
         2: return DEPTH_RESET;
         3: return '0;
         4: return 6'd63;
         default: return DEPTH_W'($urandom_range(0, 63));
      endcase
   endfunction

   // Result side: random stalls, plus a long hold-off whenever one is requested.
   initial begin
      int stall_left;
      stall_left = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            stall_left = LONG_HOLD;
            hold_request = 1'b0;
         end else if (stall_left == 0 && receiver_idles && $urandom_range(0, 99) == 0) begin
            stall_left = $urandom_range(10, 40);
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= receiver_idles ? ($urandom_range(0, 3) != 0) : 1'b1;
         end
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            sb.check_sample(rsp_pcm_sample);
      end
   end

   initial begin
      logic             is_float;
      logic [LAYOUT_W-1:0] layout;
      int               pick;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset modes: integer, 16-bit passthrough.
      send_sample(32'h7FFF_FFFF, 8'hFF);
      send_sample(32'h8000_0000, 8'h00);
      set_modes(1'b0, LAYOUT_REBUILD, DEPTH_24);
      send_sample(32'h7FFF_FFFF, 8'h00);
      send_sample(32'h8000_0000, 8'h00);
      set_modes(1'b0, LAYOUT_REBUILD, DEPTH_32);
      send_sample(32'h8000_7FFF, 8'h00);
      send_sample(32'h7FFF_8000, 8'h00);
      set_modes(1'b0, LAYOUT_REBUILD, 6'd63);
      send_sample(32'hFFFF_8000, 8'h00);
      set_modes(1'b1, LAYOUT_LOW16, '0);
      send_sample(32'h1234_8001, 8'h80);
      set_modes(1'b1, LAYOUT_SHIFT8, 6'd63);
      send_sample(32'h8000_0000, 8'h00);
      // Layout three behaves as a shift right by eight.
      set_modes(1'b1, 2'd3, DEPTH_RESET);
      send_sample(32'h7FFF_FFFF, 8'h00);
      send_sample(32'h0080_0000, 8'h00);

      set_modes(1'b1, LAYOUT_REBUILD, DEPTH_RESET);
      write_csr(CSR_SPARE, 6'h3F);
      send_sample(32'h0000_0000, 8'd0);
      send_sample(32'h007F_FFFF, 8'd0);
      send_sample(32'hFFFF_FFFF, 8'd126);
      send_sample(32'h007F_FFFF, 8'd126);
      send_sample(32'h0000_0000, EXP_ONE);
      send_sample(32'hFF80_0001, EXP_ONE);
      send_sample(32'h0000_0001, EXP_SPEC);
      send_sample(32'h0000_0000, EXP_SPEC);
      send_sample(32'h8000_0000, EXP_SPEC);
      send_sample(32'h8000_0000, 8'd100);
      send_sample(32'h7FFF_FFFF, 8'd254);
      send_sample(32'h0040_0000, 8'd126);
      send_sample(32'h0000_0001, 8'd112);

      for (int phase = 0; phase < PHASES; phase++) begin
         pick = $urandom_range(0, 9);
         is_float = (pick < 7);
         if (pick < 5)
            layout = LAYOUT_REBUILD;
         else if (pick == 5)
            layout = LAYOUT_LOW16;
         else
            layout = LAYOUT_W'($urandom_range(0, 3));
         if (phase == 0)
            set_modes(1'b1, LAYOUT_REBUILD, DEPTH_32);
         else
            set_modes(is_float, layout, random_depth());
         if ($urandom_range(0, 3) == 0)
            write_csr(CSR_SPARE, CSR_DATA_W'($urandom_range(0, 63)));
         sender_idles = (phase != 0 && phase != 3 && $urandom_range(0, 3) != 0);
         receiver_idles = (phase != 0 && $urandom_range(0, 3) != 0);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Receiver holds off while items keep coming, so the pipeline fills up.
            if (phase == 3 && i == 40)
               hold_request = 1'b1;
            if (phase == 6 && i == PHASE_ITEMS / 2)
               wait_drained();
            if (sb.is_float && sb.layout == LAYOUT_REBUILD && $urandom_range(0, 9) != 0)
               send_sample(random_float_raw(), random_float_exponent());
            else
               send_sample($urandom, EXP_W'($urandom_range(0, 255)));
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (sb.owed() != 0)
         $display("%0t: %0d pcm samples never arrived", $time, sb.owed());
      if (sb.error_count == 0 && sb.owed() == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
